[rtl/core/gwl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwl_pkg
// Shared types, constants and helpers for the greedy word-wrap line breaker.
// ----------------------------------------------------------------------------
package gwl_pkg;

  localparam int CHAR_W  = 8;
  localparam int ADV_W   = 16;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 13;
  localparam int WIDTH_W = 32;

  localparam int MAX_TEXT_LENGTH = 4096;
  localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_TEXT_LENGTH);

  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(640);
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [IDX_W-1:0]   line_start;
    logic [IDX_W-1:0]   line_end;
    logic [WIDTH_W-1:0] line_width;
    logic               final_line;
  } line_t;

  // lines produced by one accepted character, in emit order
  typedef struct packed {
    logic [1:0] count;
    line_t      first;
    line_t      second;
  } push_t;

  // index advance that sticks at the text length limit
  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] p);
    next_index = (p < IDX_LIMIT) ? p + IDX_W'(1) : IDX_LIMIT;
  endfunction

endpackage
`default_nettype wire

[rtl/core/gwl_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwl_engine
// Per-character line state and break decision; emits up to two lines a beat.
// ----------------------------------------------------------------------------
module gwl_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [gwl_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                        accept,
  input  wire logic [gwl_pkg::CHAR_W-1:0]  char_code,
  input  wire logic [gwl_pkg::ADV_W-1:0]   glyph_advance,
  input  wire logic                        end_of_text,
  output gwl_pkg::push_t                   push
);
  import gwl_pkg::*;

  logic [CFG_W-1:0]   max_line_width;
  logic [IDX_W-1:0]   char_position, char_position_next;
  logic [IDX_W-1:0]   current_line_start, current_line_start_next;
  logic               inside_word, inside_word_next;
  logic               line_has_word, line_has_word_next;
  logic [IDX_W-1:0]   last_word_end, last_word_end_next;
  logic [WIDTH_W-1:0] running_width, running_width_next;
  logic [WIDTH_W-1:0] width_at_word_end, width_at_word_end_next;
  logic [ADV_W-1:0]   break_char_advance, break_char_advance_next;

  logic [IDX_W-1:0]   nxt;
  logic               ws, nl, word_ends, brk;
  logic               iw1, lhw1;
  logic [IDX_W-1:0]   lwe1;
  logic [WIDTH_W-1:0] waw1, rw1;
  logic [ADV_W-1:0]   bca1;
  logic [WIDTH_W:0]   rw_sum, cut_sum, carry_diff;
  line_t              brk_line, fin_line;

  always_comb begin
    nxt = next_index(char_position);
    ws  = (char_code == CHAR_SPACE) || (char_code == CHAR_TAB) ||
          (char_code == CHAR_NEWLINE);
    nl  = (char_code == CHAR_NEWLINE);
    word_ends = ws && inside_word;

    iw1  = word_ends ? 1'b0 : (inside_word || !ws);
    lhw1 = line_has_word || word_ends;
    lwe1 = word_ends ? char_position : last_word_end;
    waw1 = word_ends ? running_width : width_at_word_end;
    bca1 = word_ends ? glyph_advance : break_char_advance;

    rw_sum = {1'b0, running_width} + {{(WIDTH_W+1-ADV_W){1'b0}}, glyph_advance};
    rw1    = rw_sum[WIDTH_W] ? '1 : rw_sum[WIDTH_W-1:0];

    // two stopping subtractions fold into one against the summed cut point
    cut_sum    = {1'b0, waw1} + {{(WIDTH_W+1-ADV_W){1'b0}}, bca1};
    carry_diff = {1'b0, rw1} - cut_sum;

    brk = !nl && lhw1 && (rw1 > {{(WIDTH_W-CFG_W){1'b0}}, max_line_width});

    brk_line.line_start = current_line_start;
    brk_line.line_end   = lwe1;
    brk_line.line_width = waw1;
    brk_line.final_line = 1'b0;

    current_line_start_next = current_line_start;
    running_width_next      = rw1;
    line_has_word_next      = lhw1;
    inside_word_next        = iw1;
    last_word_end_next      = lwe1;
    width_at_word_end_next  = waw1;
    break_char_advance_next = bca1;
    char_position_next      = nxt;

    if (nl) begin
      if (!lhw1) begin
        brk_line.line_end   = current_line_start;
        brk_line.line_width = '0;
      end
      current_line_start_next = nxt;
      running_width_next      = '0;
      line_has_word_next      = 1'b0;
      inside_word_next        = 1'b0;
    end else if (brk) begin
      current_line_start_next = next_index(lwe1);
      running_width_next      = ({1'b0, rw1} > cut_sum) ? carry_diff[WIDTH_W-1:0] : '0;
      line_has_word_next      = 1'b0;
    end

    fin_line.line_start = current_line_start_next;
    fin_line.line_end   = nxt;
    fin_line.line_width = running_width_next;
    fin_line.final_line = 1'b1;

    if (end_of_text) begin
      char_position_next      = '0;
      current_line_start_next = '0;
      inside_word_next        = 1'b0;
      line_has_word_next      = 1'b0;
      last_word_end_next      = '0;
      running_width_next      = '0;
      width_at_word_end_next  = '0;
      break_char_advance_next = '0;
    end

    push.count  = accept ? (2'((nl || brk) ? 1 : 0) + 2'(end_of_text)) : 2'd0;
    push.first  = (nl || brk) ? brk_line : fin_line;
    push.second = fin_line;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_width     <= CFG_RESET;
      char_position      <= '0;
      current_line_start <= '0;
      inside_word        <= 1'b0;
      line_has_word      <= 1'b0;
      last_word_end      <= '0;
      running_width      <= '0;
      width_at_word_end  <= '0;
      break_char_advance <= '0;
    end else begin
      if (cfg_we) begin
        max_line_width <= cfg_wdata;
      end
      if (accept) begin
        char_position      <= char_position_next;
        current_line_start <= current_line_start_next;
        inside_word        <= inside_word_next;
        line_has_word      <= line_has_word_next;
        last_word_end      <= last_word_end_next;
        running_width      <= running_width_next;
        width_at_word_end  <= width_at_word_end_next;
        break_char_advance <= break_char_advance_next;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/gwl_out_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwl_out_queue
// Small result queue: up to two lines pushed per cycle, one beat popped.
// ----------------------------------------------------------------------------
module gwl_out_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire gwl_pkg::push_t push,
  input  wire logic           pop,
  output logic                room_for_two,
  output logic                not_empty,
  output gwl_pkg::line_t      head
);
  import gwl_pkg::*;

  line_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign not_empty    = (count != '0);
  assign room_for_two = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign head         = mem[rd_ptr];
  assign do_pop       = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push.count) - QCNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

[rtl/core/greedy_word_wrap_line_breaker_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_word_wrap_line_breaker_core
// Greedy word wrap over a character stream; one line beat per wrapped line.
// ----------------------------------------------------------------------------
// One character beat is taken per clock. Its line state (position, open line
// start, last word end, running width) updates in the same cycle and the
// lines it closes, zero to two, are written into a four-entry result queue
// whose head feeds the output port. The sustained rate is one character per
// cycle as long as the output side drains; the input stalls only while the
// queue has fewer than two free slots, which happens when lines are produced
// faster than one a cycle (a break or a newline on the same beat as
// end_of_text) or when out_stall holds back.
// max_line_width is written through cfg_we/cfg_wdata; the user must write it
// only while no text is in flight, which the block itself does not enforce.
// It resets to 640 (ten pixels in 1/64 units).
// ----------------------------------------------------------------------------
module greedy_word_wrap_line_breaker_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [gwl_pkg::CFG_W-1:0]     cfg_wdata,
  // character beats
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [gwl_pkg::CHAR_W-1:0]    char_code,
  input  wire logic [gwl_pkg::ADV_W-1:0]     glyph_advance,
  input  wire logic                          end_of_text,
  // line beats
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [gwl_pkg::IDX_W-1:0]          line_start,
  output logic [gwl_pkg::IDX_W-1:0]          line_end,
  output logic [gwl_pkg::WIDTH_W-1:0]        line_width,
  output logic                               final_line
);
  import gwl_pkg::*;

  push_t push;
  line_t head;
  logic  accept;
  logic  room_for_two;

  // a character may close two lines, so keep two slots free before taking it
  assign in_stall = !room_for_two;
  assign accept   = in_valid && !in_stall;

  gwl_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .accept        (accept),
    .char_code     (char_code),
    .glyph_advance (glyph_advance),
    .end_of_text   (end_of_text),
    .push          (push)
  );

  gwl_out_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .pop          (!out_stall),
    .room_for_two (room_for_two),
    .not_empty    (out_valid),
    .head         (head)
  );

  assign line_start = head.line_start;
  assign line_end   = head.line_end;
  assign line_width = head.line_width;
  assign final_line = head.final_line;

endmodule
`default_nettype wire

[rtl/core/gwl_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwl_checker
// Port-level checks for the line breaker, bound to the top level.
// ----------------------------------------------------------------------------
module gwl_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [gwl_pkg::IDX_W-1:0]   line_start,
  input wire logic [gwl_pkg::IDX_W-1:0]   line_end,
  input wire logic [gwl_pkg::WIDTH_W-1:0] line_width,
  input wire logic                        final_line
);
  import gwl_pkg::*;

  // queue comes up empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("line beat valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(line_start) &&
      $stable(line_end) && $stable(line_width) && $stable(final_line))
    else $error("stalled line beat changed");

  // input only backs up while lines are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result queue");

  a_span: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (line_start <= line_end) && (line_end <= IDX_LIMIT))
    else $error("line span out of order");

  // an empty non-final line only comes from a bare newline
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !final_line && (line_start == line_end) |-> (line_width == '0))
    else $error("empty line with nonzero width");

endmodule

bind greedy_word_wrap_line_breaker_core gwl_checker u_gwl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .line_start (line_start),
  .line_end   (line_end),
  .line_width (line_width),
  .final_line (final_line)
);
`default_nettype wire

[verif/gwl_line_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwl_line_checker
// Watches the character and line channels and the config port. Keeps its own
// greedy word-wrap state and compares every line beat with the oldest line
// still owed.
// ----------------------------------------------------------------------------
module gwl_line_checker
  import gwl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic [ADV_W-1:0]   glyph_advance,
  input  logic               end_of_text,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [IDX_W-1:0]   line_start,
  input  logic [IDX_W-1:0]   line_end,
  input  logic [WIDTH_W-1:0] line_width,
  input  logic               final_line,
  output int                 fail_count,
  output int                 lines_pending
);

  localparam int REPORT_MAX = 10;
  localparam logic [IDX_W-1:0] POS_CAP = IDX_W'(MAX_TEXT_LENGTH);

  logic [CFG_W-1:0]   wrap_limit;
  logic [IDX_W-1:0]   pos;
  logic [IDX_W-1:0]   line_begin;
  logic [IDX_W-1:0]   word_end;
  logic               in_word;
  logic               have_word;
  logic [WIDTH_W-1:0] run_w;
  logic [WIDTH_W-1:0] w_at_end;
  logic [ADV_W-1:0]   brk_adv;
  line_t              owed_lines[$];

  // position counter sticks once the text hits its length cap
  function automatic logic [IDX_W-1:0] idx_step(input logic [IDX_W-1:0] p);
    return (p < POS_CAP) ? p + IDX_W'(1) : POS_CAP;
  endfunction

  function automatic logic [WIDTH_W-1:0] add_sat(input logic [WIDTH_W-1:0] a,
                                                 input logic [WIDTH_W-1:0] b);
    logic [WIDTH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WIDTH_W] ? '1 : s[WIDTH_W-1:0];
  endfunction

  function automatic logic [WIDTH_W-1:0] sub_floor(input logic [WIDTH_W-1:0] a,
                                                   input logic [WIDTH_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  task automatic owe_line(input logic [IDX_W-1:0] s, input logic [IDX_W-1:0] e,
                          input logic [WIDTH_W-1:0] w, input logic fin);
    line_t ln;
    ln.line_start = s;
    ln.line_end   = e;
    ln.line_width = w;
    ln.final_line = fin;
    owed_lines.push_back(ln);
  endtask

  task automatic clear_text();
    pos        = '0;
    line_begin = '0;
    in_word    = 1'b0;
    have_word  = 1'b0;
    word_end   = '0;
    run_w      = '0;
    w_at_end   = '0;
    brk_adv    = '0;
  endtask

  task automatic wrap_char(input logic [CHAR_W-1:0] c, input logic [ADV_W-1:0] adv,
                           input logic eot);
    logic [IDX_W-1:0] nxt;
    logic is_ws;
    nxt   = idx_step(pos);
    is_ws = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NEWLINE);
    if (!is_ws && !in_word) begin
      in_word = 1'b1;
    end else if (is_ws && in_word) begin
      word_end  = pos;
      w_at_end  = run_w;
      brk_adv   = adv;
      have_word = 1'b1;
      in_word   = 1'b0;
    end
    run_w = add_sat(run_w, WIDTH_W'(adv));
    if (c == CHAR_NEWLINE) begin
      if (have_word) owe_line(line_begin, word_end, w_at_end, 1'b0);
      else           owe_line(line_begin, line_begin, '0, 1'b0);
      line_begin = nxt;
      run_w      = '0;
      have_word  = 1'b0;
      in_word    = 1'b0;
    end else if (run_w > WIDTH_W'(wrap_limit) && have_word) begin
      // width break: carry the tail past the break whitespace
      owe_line(line_begin, word_end, w_at_end, 1'b0);
      line_begin = idx_step(word_end);
      run_w      = sub_floor(sub_floor(run_w, w_at_end), WIDTH_W'(brk_adv));
      have_word  = 1'b0;
    end
    if (eot) begin
      owe_line(line_begin, nxt, run_w, 1'b1);
      clear_text();
    end else begin
      pos = nxt;
    end
  endtask

  always @(posedge clk) begin
    line_t want;
    if (rst) begin
      wrap_limit = CFG_RESET;
      clear_text();
      owed_lines.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) wrap_limit = cfg_wdata;
      // input first: a line can never leave in the same beat as its character
      if (in_valid && !in_stall) wrap_char(char_code, glyph_advance, end_of_text);
      if (out_valid && !out_stall) begin
        if (owed_lines.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected line: start %0d end %0d width %0d final %0b",
                     line_start, line_end, line_width, final_line);
        end else begin
          want = owed_lines.pop_front();
          if (line_start !== want.line_start || line_end !== want.line_end ||
              line_width !== want.line_width || final_line !== want.final_line) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display({"line mismatch (exp/got): start %0d/%0d end %0d/%0d ",
                        "width %0d/%0d final %0b/%0b"},
                       want.line_start, line_start, want.line_end, line_end,
                       want.line_width, line_width, want.final_line, final_line);
          end
        end
      end
    end
    lines_pending = owed_lines.size();
  end

endmodule

[verif/greedy_word_wrap_line_breaker_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_word_wrap_line_breaker_core_tb
// Feeds texts to the line breaker, one character beat at a time, and lets
// gwl_line_checker predict and compare the line beats. A short directed part
// hits newlines, width breaks, long words, a break on the last character and
// field extremes; one long word at maximum advance overruns the wrap width
// alone until the space after it forces a break; then random texts run under
// changing wrap widths with bursts of idle and back-pressure on both channels.
// ----------------------------------------------------------------------------
module greedy_word_wrap_line_breaker_core_tb;
  import gwl_pkg::*;

  localparam int RANDOM_CHARS   = 390;
  localparam int CALM_TAIL      = 70;      // last chars run with no idling
  localparam int LONG_WORD_LEN  = 24;      // max advances, far past the wrap width
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               cfg_we        = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata     = '0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [CHAR_W-1:0]  char_code     = '0;
  logic [ADV_W-1:0]   glyph_advance = '0;
  logic               end_of_text   = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [IDX_W-1:0]   line_start;
  logic [IDX_W-1:0]   line_end;
  logic [WIDTH_W-1:0] line_width;
  logic               final_line;

  int fail_count;
  int lines_pending;

  // knobs for the idle generators
  logic src_gaps    = 1'b0;
  logic sink_stalls = 1'b0;
  logic calm        = 1'b0;

  int chars_sent   = 0;
  int stuck_cycles = 0;
  int unsigned hold_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  greedy_word_wrap_line_breaker_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_code     (char_code),
    .glyph_advance (glyph_advance),
    .end_of_text   (end_of_text),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .line_start    (line_start),
    .line_end      (line_end),
    .line_width    (line_width),
    .final_line    (final_line)
  );

  gwl_line_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_code     (char_code),
    .glyph_advance (glyph_advance),
    .end_of_text   (end_of_text),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .line_start    (line_start),
    .line_end      (line_end),
    .line_width    (line_width),
    .final_line    (final_line),
    .fail_count    (fail_count),
    .lines_pending (lines_pending)
  );

  // Line-side back-pressure: stall bursts of random length, started at random.
  always @(posedge clk) begin
    if (rst || calm || !sink_stalls) begin
      hold_left = 0;
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 6) == 0) begin
      hold_left = $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: any long run of cycles with no beat on either side is a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // One character beat. Optionally idles first, then holds the beat until
  // the block takes it. in_stall is read at the falling edge, where it is
  // settled, and the task returns on the accepting rising edge.
  task automatic push_char(input logic [CHAR_W-1:0] c, input logic [ADV_W-1:0] adv,
                           input logic eot);
    logic held;
    if (src_gaps && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    char_code     <= c;
    glyph_advance <= adv;
    end_of_text   <= eot;
    do begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
    end while (held);
  endtask

  // Drop valid after the last beat of a text.
  task automatic close_text();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every owed line has come out, plus a few cycles of slack for
  // anything still moving through the result queue.
  task automatic drain_lines();
    do @(negedge clk); while (lines_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_wrap_limit(input logic [CFG_W-1:0] v);
    drain_lines();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CFG_RESET;
      5:       return CFG_W'($urandom_range(0, 24'hFFFFFF));
      default: return CFG_W'($urandom_range(60, 2000));
    endcase
  endfunction

  // Any byte that is not whitespace, mostly printable.
  function automatic logic [CHAR_W-1:0] pick_glyph();
    logic [CHAR_W-1:0] c;
    if ($urandom_range(0, 3) != 0) c = CHAR_W'($urandom_range(33, 126));
    else                           c = CHAR_W'($urandom_range(0, 255));
    if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NEWLINE) c = 8'd65;
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_space();
    case ($urandom_range(0, 9))
      0, 1:    return CHAR_TAB;
      2, 3:    return CHAR_NEWLINE;
      default: return CHAR_SPACE;
    endcase
  endfunction

  function automatic logic [ADV_W-1:0] pick_adv(input logic wide);
    if (wide) begin
      case ($urandom_range(0, 7))
        0:       return '0;
        1:       return '1;
        default: return ADV_W'($urandom_range(0, 65535));
      endcase
    end
    return ADV_W'($urandom_range(0, 150));
  endfunction

  // A random text: words of 1 to 8 glyphs between whitespace, with some
  // stray random bytes mixed in; the last character carries end_of_text.
  task automatic feed_text(input int len, input logic wide);
    int word_left;
    logic [CHAR_W-1:0] c;
    word_left = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        c = CHAR_W'($urandom_range(0, 255));
      end else if (word_left == 0) begin
        c = pick_space();
        word_left = $urandom_range(1, 8);
      end else begin
        c = pick_glyph();
        word_left--;
      end
      push_char(c, pick_adv(wide), i == len - 1);
    end
    close_text();
    chars_sent += len;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;

    // Directed, wrap width at its reset value.
    // Newline with no word yet gives an empty line; a wide glyph word that
    // overruns alone does not break; the space after it breaks the line.
    push_char(CHAR_NEWLINE, 16'd7, 1'b0);
    push_char(8'hFF, 16'hFFFF, 1'b0);
    push_char(8'h00, 16'd0, 1'b0);
    push_char(CHAR_SPACE, 16'd20, 1'b0);
    push_char(8'd113, 16'd5, 1'b0);
    push_char(CHAR_TAB, 16'd1, 1'b0);
    // break and end of text on the same character: two lines
    push_char(8'd122, 16'd700, 1'b1);
    close_text();
    // text ending in a newline leaves an empty final line
    push_char(8'd97, 16'd100, 1'b0);
    push_char(8'd98, 16'd100, 1'b0);
    push_char(CHAR_NEWLINE, 16'd3, 1'b1);
    close_text();
    push_char(8'd107, 16'd9, 1'b1);
    close_text();

    // Zero wrap width: every finished word breaks at once.
    set_wrap_limit('0);
    push_char(8'd11, 16'd1, 1'b0);
    push_char(CHAR_SPACE, 16'd1, 1'b0);
    push_char(8'd31, 16'd1, 1'b0);
    push_char(CHAR_TAB, 16'd1, 1'b0);
    push_char(8'd33, 16'd0, 1'b0);
    push_char(CHAR_NEWLINE, 16'hFFFF, 1'b0);
    push_char(CHAR_SPACE, 16'd4, 1'b0);
    push_char(8'd128, 16'd2, 1'b1);
    close_text();

    // One long word at max advance overruns the wrap width without a break;
    // the space after it forces the break, and the short words that follow
    // fit on the next line.
    set_wrap_limit(CFG_RESET);
    src_gaps = 1'b0;
    for (int i = 0; i < LONG_WORD_LEN; i++) push_char(pick_glyph(), '1, 1'b0);
    push_char(CHAR_SPACE, '1, 1'b0);
    push_char(8'd97, 16'd7, 1'b0);
    push_char(CHAR_SPACE, 16'd1, 1'b0);
    push_char(8'd98, 16'd3, 1'b1);
    close_text();

    // Random texts under changing wrap widths; the tail runs without idling.
    set_wrap_limit(CFG_RESET);
    while (chars_sent < RANDOM_CHARS) begin
      if (chars_sent >= RANDOM_CHARS - CALM_TAIL) calm = 1'b1;
      if ($urandom_range(0, 2) == 0) set_wrap_limit(pick_limit());
      src_gaps    = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      feed_text($urandom_range(4, 40), $urandom_range(0, 3) == 0);
    end

    drain_lines();
    @(negedge clk);
    if (fail_count == 0 && lines_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[greedy_word_wrap_line_breaker_core.f]
rtl/core/gwl_pkg.sv
rtl/core/gwl_engine.sv
rtl/core/gwl_out_queue.sv
rtl/core/greedy_word_wrap_line_breaker_core.sv
rtl/core/gwl_checker.sv
verif/gwl_line_checker.sv
verif/greedy_word_wrap_line_breaker_core_tb.sv
